FILE: design/tkss_pkg.sv
package tkss_pkg;

    localparam int DIST_W    = 32;
    localparam int LABEL_W   = 32;
    localparam int KCFG_W    = 7;
    localparam int MAX_K_DEF = 64;
    localparam int K_RESET   = 10;
    localparam int ENTRY_W   = DIST_W + LABEL_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_EVCMP,
        S_RD,
        S_CMP,
        S_EMRD,
        S_EMLD
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic accept;      // latch the incoming request
        logic grow;        // insert into a free slot: pos <= held, held++
        logic rd_evict;    // read the largest held entry
        logic ins_evict;   // replace largest: pos <= held-1
        logic rd_prev;     // read entry at pos-1
        logic shift;       // mem[pos] <= read data, pos--
        logic place;       // mem[pos] <= new request
        logic rd_emit;     // read entry at emit index
        logic load_out;    // load output register, index++
        logic clear;       // store empties
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic not_full;
        logic pos_zero;
        logic rd_gt;
        logic last_flag;
        logic out_free;
        logic emit_last;
    } t_sts;

endpackage

FILE: design/tkss_ram.sv
module tkss_ram #(
    parameter int W     = 64,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/tkss_ctrl.sv
module tkss_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    output logic           o_s_tready,
    input  tkss_pkg::t_sts i_sts,
    output tkss_pkg::t_cmd o_cmd
);

    import tkss_pkg::*;

    t_state r_state;
    t_state n_state;
    t_cmd   cmd;
    t_state done_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        cmd        = '0;
        o_s_tready = 1'b0;
        done_state = i_sts.last_flag ? S_EMRD : S_IDLE;
        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    cmd.accept = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.not_full) begin
                    cmd.grow = 1'b1;
                    n_state  = S_RD;
                end else begin
                    cmd.rd_evict = 1'b1;
                    n_state      = S_EVCMP;
                end
            end
            S_EVCMP: begin
                if (i_sts.rd_gt) begin
                    cmd.ins_evict = 1'b1;
                    n_state       = S_RD;
                end else begin
                    n_state = done_state;
                end
            end
            S_RD: begin
                if (i_sts.pos_zero) begin
                    cmd.place = 1'b1;
                    n_state   = done_state;
                end else begin
                    cmd.rd_prev = 1'b1;
                    n_state     = S_CMP;
                end
            end
            S_CMP: begin
                if (i_sts.rd_gt) begin
                    cmd.shift = 1'b1;
                    n_state   = S_RD;
                end else begin
                    cmd.place = 1'b1;
                    n_state   = done_state;
                end
            end
            S_EMRD: begin
                cmd.rd_emit = 1'b1;
                n_state     = S_EMLD;
            end
            S_EMLD: begin
                cmd.rd_emit = 1'b1;
                if (i_sts.out_free) begin
                    cmd.load_out = 1'b1;
                    if (i_sts.emit_last) begin
                        cmd.clear = 1'b1;
                        n_state   = S_IDLE;
                    end else begin
                        n_state = S_EMRD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cmd = cmd;

    a_ins_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !((cmd.shift || cmd.place) && (cmd.load_out || cmd.accept)))
        else $error("store write overlaps request or emit");

    a_place_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.place && !i_sts.last_flag |=> r_state == S_IDLE)
        else $error("insert did not return to idle");

    a_clear_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.clear |=> o_s_tready)
        else $error("not ready after batch emitted");

endmodule

FILE: design/tkss_dp.sv
module tkss_dp #(
    parameter int MAX_K = tkss_pkg::MAX_K_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [tkss_pkg::DIST_W+tkss_pkg::LABEL_W-1:0] i_s_tdata,
    input  logic                              i_s_tlast,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [tkss_pkg::ENTRY_W-1:0]      o_m_tdata,
    output logic                              o_m_tlast,
    input  logic                              i_cfg_we,
    input  logic [tkss_pkg::KCFG_W-1:0]       i_cfg_wdata,
    input  tkss_pkg::t_cmd                    i_cmd,
    output tkss_pkg::t_sts                    o_sts
);

    import tkss_pkg::*;

    localparam int AW = (MAX_K > 1) ? $clog2(MAX_K) : 1;
    localparam int CW = $clog2(MAX_K + 1);

    logic [KCFG_W-1:0]  r_k;
    logic [KCFG_W-1:0]  k_eff;
    logic [CW-1:0]      r_held;
    logic [CW-1:0]      held_m1;
    logic [AW-1:0]      r_pos;
    logic [AW-1:0]      r_idx;
    logic [DIST_W-1:0]  r_dist;
    logic [LABEL_W-1:0] r_label;
    logic               r_last;
    logic               r_ovalid;
    logic [ENTRY_W-1:0] r_odata;
    logic               r_olast;
    logic [ENTRY_W-1:0] rdata;
    logic [ENTRY_W-1:0] wdata;
    logic [AW-1:0]      raddr;
    logic               we;
    logic               out_free;
    logic               emit_last;

    assign held_m1 = r_held - CW'(1);
    assign k_eff   = (r_k == '0) ? KCFG_W'(1) :
                     ((r_k > KCFG_W'(MAX_K)) ? KCFG_W'(MAX_K) : r_k);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= KCFG_W'(K_RESET);
        end else if (i_cfg_we) begin
            r_k <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_dist  <= i_s_tdata[DIST_W-1:0];
            r_label <= i_s_tdata[ENTRY_W-1:DIST_W];
            r_last  <= i_s_tlast;
        end
        if (i_cmd.grow) begin
            r_pos <= r_held[AW-1:0];
        end else if (i_cmd.ins_evict) begin
            r_pos <= held_m1[AW-1:0];
        end else if (i_cmd.shift) begin
            r_pos <= r_pos - AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
            r_idx  <= '0;
        end else begin
            if (i_cmd.clear) begin
                r_held <= '0;
                r_idx  <= '0;
            end else begin
                if (i_cmd.grow) begin
                    r_held <= r_held + CW'(1);
                end
                if (i_cmd.load_out) begin
                    r_idx <= r_idx + AW'(1);
                end
            end
        end
    end

    // store: {label, distance}, sorted ascending
    assign we    = i_cmd.shift | i_cmd.place;
    assign wdata = i_cmd.shift ? rdata : {r_label, r_dist};
    assign raddr = i_cmd.rd_evict ? held_m1[AW-1:0] :
                   (i_cmd.rd_prev ? (r_pos - AW'(1)) : r_idx);

    tkss_ram #(
        .W     (ENTRY_W),
        .DEPTH (MAX_K)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_pos),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // output register
    assign out_free  = !r_ovalid || i_m_tready;
    assign emit_last = (CW'(r_idx) == held_m1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_ovalid <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_odata <= rdata;
            r_olast <= emit_last;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign o_m_tlast  = r_olast;

    assign o_sts.not_full  = KCFG_W'(r_held) < k_eff;
    assign o_sts.pos_zero  = (r_pos == '0);
    assign o_sts.rd_gt     = rdata[DIST_W-1:0] > r_dist;
    assign o_sts.last_flag = r_last;
    assign o_sts.out_free  = out_free;
    assign o_sts.emit_last = emit_last;

    a_held_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CW'(MAX_K) >= r_held)
        else $error("held count above store depth");

    a_emit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> CW'(r_idx) < r_held)
        else $error("emit index beyond held entries");

    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear |=> r_held == '0 && r_ovalid)
        else $error("store not emptied after final result");

endmodule

FILE: design/top_k_smallest_selector_unit.sv
// channel | dir | handshake               | payload
// s       | in  | i_s_tvalid / o_s_tready | tdata {label, distance}, tlast = last_in
// m       | out | o_m_tvalid / i_m_tready | tdata {out_label, out_distance}, tlast = last_out
// cfg     | in  | i_cfg_we                | i_cfg_wdata = k_count
//
// Per request: a rejected entry ends after the compare with the largest held entry; else the
// sorted insert moves held entries up one at a time in the single-port read/shift loop.
// On tlast: results are read out in order through the same RAM port and wait on output stalls.
// Reset: synchronous, active low; store empty, k_count = 10.
// The output register lets a new request enter while the final result waits.
module top_k_smallest_selector_unit #(
    parameter int MAX_K = tkss_pkg::MAX_K_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [tkss_pkg::ENTRY_W-1:0] i_s_tdata,   // [31:0] distance, [63:32] label
    input  logic                         i_s_tlast,
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    output logic [tkss_pkg::ENTRY_W-1:0] o_m_tdata,   // [31:0] out_distance, [63:32] out_label
    output logic                         o_m_tlast,
    input  logic                         i_cfg_we,
    input  logic [tkss_pkg::KCFG_W-1:0]  i_cfg_wdata
);

    import tkss_pkg::*;

    t_cmd cmd;
    t_sts sts;

    tkss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    tkss_dp #(
        .MAX_K (MAX_K)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule

FILE: bench/testbench.sv
module testbench;

    localparam int DIST_W      = tkss_pkg::DIST_W;
    localparam int LABEL_W     = tkss_pkg::LABEL_W;
    localparam int KCFG_W      = tkss_pkg::KCFG_W;
    localparam int ENTRY_W     = tkss_pkg::ENTRY_W;
    localparam int MAX_K       = tkss_pkg::MAX_K_DEF;
    localparam int IDLE_CYCLES = 2 * MAX_K + 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 320;

    typedef struct packed {
        logic [DIST_W-1:0]  dist_val;
        logic [LABEL_W-1:0] label;
        logic               last;
    } t_neighbor;

    class topk_scoreboard;
        logic [DIST_W-1:0]  kept_dist [MAX_K];
        logic [LABEL_W-1:0] kept_label [MAX_K];
        int unsigned        held;
        logic [KCFG_W-1:0]  k_limit;
        t_neighbor          emit_q [$];
        int                 errors;

        function new();
            held    = 0;
            k_limit = KCFG_W'(tkss_pkg::K_RESET);
            errors  = 0;
        endfunction

        function void set_limit(logic [KCFG_W-1:0] v);
            k_limit = v;
        endfunction

        function int unsigned active_limit();
            if (k_limit == 0) return 1;
            if (k_limit > MAX_K) return MAX_K;
            return k_limit;
        endfunction

        // stable insert: equal distances stay in arrival order
        function void insert_sorted(logic [DIST_W-1:0] d, logic [LABEL_W-1:0] lab);
            int unsigned pos;
            pos = held;
            while (pos > 0 && kept_dist[pos-1] > d) begin
                kept_dist[pos]  = kept_dist[pos-1];
                kept_label[pos] = kept_label[pos-1];
                pos--;
            end
            kept_dist[pos]  = d;
            kept_label[pos] = lab;
            held++;
        endfunction

        function void note_request(logic [DIST_W-1:0] d, logic [LABEL_W-1:0] lab,
                                   logic last);
            t_neighbor e;
            if (held < active_limit()) begin
                insert_sorted(d, lab);
            end else if (held > 0 && kept_dist[held-1] > d) begin
                held--;
                insert_sorted(d, lab);
            end
            if (last) begin
                for (int unsigned i = 0; i < held; i++) begin
                    e.dist_val = kept_dist[i];
                    e.label    = kept_label[i];
                    e.last     = (i + 1 == held);
                    emit_q.insert(emit_q.size(), e);
                end
                held = 0;
            end
        endfunction

        function void check_result(logic [DIST_W-1:0] d, logic [LABEL_W-1:0] lab,
                                   logic last);
            t_neighbor e;
            if (emit_q.size() == 0) begin
                $error("unexpected result: out_distance %h out_label %h last_out %b",
                       d, lab, last);
                errors++;
                return;
            end
            e = emit_q.pop_front();
            if (d !== e.dist_val) begin
                $error("out_distance: expected %h, actual %h", e.dist_val, d);
                errors++;
            end
            if (lab !== e.label) begin
                $error("out_label: expected %h, actual %h", e.label, lab);
                errors++;
            end
            if (last !== e.last) begin
                $error("last_out: expected %b, actual %b", e.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return emit_q.size();
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_s_tvalid = 1'b0;
    logic               o_s_tready;
    logic [ENTRY_W-1:0] i_s_tdata = '0;
    logic               i_s_tlast = 1'b0;
    logic               o_m_tvalid;
    logic               i_m_tready = 1'b0;
    logic [ENTRY_W-1:0] o_m_tdata;
    logic               o_m_tlast;
    logic               i_cfg_we = 1'b0;
    logic [KCFG_W-1:0]  i_cfg_wdata = '0;

    topk_scoreboard sb = new();
    int             cycle_count = 0;
    logic [9:0]     stall_phase = '0;
    int             burst_left = 0;
    int             batch_left = 0;

    top_k_smallest_selector_unit #(.MAX_K(MAX_K)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // receiver: checks results, stalls on a rotating pattern
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            sb.check_result(o_m_tdata[DIST_W-1:0], o_m_tdata[ENTRY_W-1:DIST_W], o_m_tlast);
        end
        stall_phase <= stall_phase + 1'b1;
        case (stall_phase[9:8])
            2'd0: begin
                i_m_tready <= 1'b1;
            end
            2'd1: begin
                i_m_tready <= 1'($urandom_range(0, 1));
            end
            2'd2: begin
                i_m_tready <= (stall_phase[2:0] < 3'd5);
            end
            default: begin
                i_m_tready <= ($urandom_range(0, 3) != 0);
            end
        endcase
    end

    task automatic send_item(input logic [DIST_W-1:0] d, input logic [LABEL_W-1:0] lab,
                             input logic last);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 16);
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {lab, d};
        i_s_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.note_request(d, lab, last);
    endtask

    // block idle: all results out, last insert finished
    task automatic settle();
        i_s_tvalid <= 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (IDLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [KCFG_W-1:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_limit(v);
    endtask

    function automatic logic [DIST_W-1:0] pick_distance();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2, 3: return DIST_W'($urandom_range(0, 7));
            default: return DIST_W'($urandom);
        endcase
    endfunction

    function automatic logic [KCFG_W-1:0] pick_limit(int phase);
        int r;
        case (phase)
            0: return 7'd127;
            1: return 7'd64;
            2: return 7'd0;
            3: return 7'd1;
            default: begin
                r = $urandom_range(0, 9);
                if (r < 6) return KCFG_W'($urandom_range(1, 12));
                if (r == 6) return KCFG_W'($urandom_range(13, 63));
                if (r == 7) return 7'd64;
                if (r == 8) return KCFG_W'($urandom_range(65, 127));
                return 7'd0;
            end
        endcase
    endfunction

    initial begin
        int phase;
        int sent;
        int phase_items;
        int keff;
        logic last;
        logic [KCFG_W-1:0] kv;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset limit of ten, extremes and ties
        send_item(32'h0000_0000, 32'h0000_0000, 1'b0);
        send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_item(32'h0000_0007, 32'h0000_0005, 1'b0);
        send_item(32'hFFFF_FFFF, 32'h0000_0001, 1'b0);
        send_item(32'h0000_0000, 32'h0000_0002, 1'b1);
        send_item(32'h0000_007B, 32'h0000_0009, 1'b1);
        settle();

        write_limit(7'd1);
        send_item(32'd5, 32'd1, 1'b0);
        send_item(32'd3, 32'd2, 1'b0);
        send_item(32'd3, 32'd3, 1'b0);
        send_item(32'd7, 32'd4, 1'b0);
        send_item(32'd3, 32'd5, 1'b1);
        settle();

        // zero limit acts as one
        write_limit(7'd0);
        send_item(32'd9, 32'd1, 1'b0);
        send_item(32'd2, 32'd2, 1'b0);
        send_item(32'd2, 32'd3, 1'b1);
        settle();

        // equal maxima: latest one is evicted
        write_limit(7'd2);
        send_item(32'd4, 32'd1, 1'b0);
        send_item(32'd4, 32'd2, 1'b0);
        send_item(32'd4, 32'd3, 1'b0);
        send_item(32'd1, 32'd4, 1'b1);
        settle();

        // limit lowered below held count mid-batch
        write_limit(7'd5);
        send_item(32'd8, 32'hA5A5_0001, 1'b0);
        send_item(32'd6, 32'hA5A5_0002, 1'b0);
        send_item(32'd6, 32'hA5A5_0003, 1'b0);
        send_item(32'd9, 32'hA5A5_0004, 1'b0);
        send_item(32'd2, 32'hA5A5_0005, 1'b0);
        settle();
        write_limit(7'd2);
        send_item(32'd7, 32'h5A5A_0006, 1'b0);
        send_item(32'd1, 32'h5A5A_0007, 1'b1);
        settle();

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            kv = pick_limit(phase);
            write_limit(kv);
            keff = (kv == 0) ? 1 : ((kv > MAX_K) ? MAX_K : int'(kv));
            phase_items = (keff > 16) ? $urandom_range(70, 100) : $urandom_range(10, 40);
            for (int j = 0; j < phase_items; j++) begin
                if (batch_left == 0) begin
                    batch_left = ($urandom_range(0, 1) == 0) ?
                                 $urandom_range(1, keff + 4) : $urandom_range(1, 2 * keff + 2);
                end
                last = (batch_left == 1);
                if (j == phase_items - 1 && $urandom_range(0, 2) != 0) last = 1'b1;
                send_item(pick_distance(), $urandom, last);
                batch_left = last ? 0 : batch_left - 1;
                sent++;
            end
            settle();
            phase++;
        end
        send_item(pick_distance(), $urandom, 1'b1);
        settle();

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
